FILE: rtl/core/rank_pair_channel_mapper_assert.svh
// assertion macros for the rank pair channel mapper checker
// depends on a clk and rst_n in the scope that uses them
`ifndef RANK_PAIR_CHANNEL_MAPPER_ASSERT_SVH
`define RANK_PAIR_CHANNEL_MAPPER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RPCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rpcm_pkg.sv
// shared types and constants for the rank pair channel mapper
// no dependencies
package rpcm_pkg;

    localparam int BRIGHT_W = 30;
    localparam int READ_W   = 12;
    localparam int DIR_W    = 16;
    localparam int FIELD_W  = 7;
    localparam int COUNT_W  = 8;

    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = {BRIGHT_W{1'b1}};
    // brightness * 100 > 2^28 is the same as brightness > floor(2^28 / 100)
    localparam logic [BRIGHT_W-1:0] ACTIVE_LIMIT = BRIGHT_W'((2 ** 28) / 100);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [1:0] REG_SUN_X = 2'd0;
    localparam logic [1:0] REG_SUN_Y = 2'd1;
    localparam logic [1:0] REG_SUN_Z = 2'd2;

    typedef struct packed {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
    } rpcm_sun_t;

    typedef struct packed {
        logic [BRIGHT_W-1:0] bright;
        logic [READ_W-1:0]   reading;
        logic                active;
        logic                last;
    } rpcm_rec_t;

    typedef enum logic [2:0] {
        BK_LOAD,
        BK_SCAN,
        BK_DRAIN,
        BK_WRITE,
        BK_FETCH,
        BK_EMIT
    } rpcm_state_t;

endpackage

FILE: rtl/core/rpcm_fifo.sv
// two-entry record queue between the front and back parts
// depends on rpcm_pkg
module rpcm_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  rpcm_pkg::rpcm_rec_t wr_data,
    output logic              full,
    input  logic              rd,
    output rpcm_pkg::rpcm_rec_t rd_data,
    output logic              empty
);
    import rpcm_pkg::*;

    rpcm_rec_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full    = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QPTR_W + 1)'(do_wr) - (QPTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/core/rpcm_front.sv
// front part: takes items, forms the clamped dot product and the active flag
// depends on rpcm_pkg
module rpcm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_x,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_y,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_z,
    input  logic [rpcm_pkg::READ_W-1:0]       raw_level,
    input  logic                              final_item,
    input  rpcm_pkg::rpcm_sun_t               sun,
    output logic                              rec_wr,
    output rpcm_pkg::rpcm_rec_t               rec,
    input  logic                              q_full
);
    import rpcm_pkg::*;

    logic               vld_reg, vld_next;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [READ_W-1:0]  raw_reg;
    logic               last_reg;
    logic signed [33:0] sum;
    logic [BRIGHT_W-1:0] bright;
    logic               accept;

    assign rec_wr = vld_reg && !q_full;
    assign full   = vld_reg && q_full;
    assign accept = push && !full;

    // three-term sum is exact in 34-bit signed q6.28
    always_comb
    begin
        sum = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        if (sum[33])
            bright = '0;
        else if (sum[32:30] != 3'd0)
            bright = BRIGHT_MAX;
        else
            bright = sum[29:0];
        rec.bright  = bright;
        rec.reading = raw_reg;
        rec.active  = (bright > ACTIVE_LIMIT);
        rec.last    = last_reg;
        vld_next    = accept ? 1'b1 : (rec_wr ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg   <= $signed(pos_x) * $signed(sun.x);
            py_reg   <= $signed(pos_y) * $signed(sun.y);
            pz_reg   <= $signed(pos_z) * $signed(sun.z);
            raw_reg  <= raw_level;
            last_reg <= final_item;
        end
    end

endmodule

FILE: rtl/core/rpcm_back.sv
// back part: stores records, ranks both lists by counting passes, emits pairs
// depends on rpcm_pkg
module rpcm_back #(
    parameter int SENSOR_TOTAL = 80
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  rpcm_pkg::rpcm_rec_t             q_data,
    output logic                            q_rd,
    output logic                            empty,
    input  logic                            pop,
    output logic [rpcm_pkg::FIELD_W-1:0]    pos_first,
    output logic [rpcm_pkg::FIELD_W-1:0]    chan_first,
    output logic [rpcm_pkg::FIELD_W-1:0]    pos_second,
    output logic [rpcm_pkg::FIELD_W-1:0]    chan_second,
    output logic [rpcm_pkg::COUNT_W-1:0]    active_count,
    output logic                            run_end
);
    import rpcm_pkg::*;

    localparam int IDX_W = $clog2(SENSOR_TOTAL);
    localparam int CNT_W = $clog2(SENSOR_TOTAL + 1);

    logic [BRIGHT_W-1:0] bright_mem [SENSOR_TOTAL];
    logic [READ_W-1:0]   read_mem   [SENSOR_TOTAL];
    logic [IDX_W-1:0]    pos_mem    [SENSOR_TOTAL];
    logic [IDX_W-1:0]    chan_mem   [SENSOR_TOTAL];

    rpcm_state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] tally_reg, tally_next;
    logic [CNT_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] scan_d_reg;
    logic             scan_vld_reg;
    logic [IDX_W-1:0] rank_p_reg, rank_p_next;
    logic [IDX_W-1:0] rank_c_reg, rank_c_next;
    logic [CNT_W-1:0] pair_reg, pair_next;
    logic             two_reg;

    logic [BRIGHT_W-1:0] key_b_q, scan_b_q;
    logic [READ_W-1:0]   key_r_q, scan_r_q;
    logic [IDX_W-1:0]    p0_q, p1_q, c0_q, c1_q;

    logic             out_vld_reg, out_vld_next;
    logic [FIELD_W-1:0] pf_reg, cf_reg, ps_reg, cs_reg;
    logic [COUNT_W-1:0] ac_reg;
    logic             end_reg;

    logic store_en, scan_issue, ord_we, fetch, out_load;
    logic scan_done, key_done, last_pair, two_now;
    logic [CNT_W:0]   pair_p1, pair_p2;
    logic [IDX_W-1:0] a0, a1;
    logic             p_before, c_before;

    assign pair_p1   = (CNT_W + 1)'(pair_reg) + 1'b1;
    assign pair_p2   = (CNT_W + 1)'(pair_reg) + 2'd2;
    assign last_pair = (pair_p2 >= (CNT_W + 1)'(cnt_reg));
    assign two_now   = (pair_p1 < (CNT_W + 1)'(cnt_reg));
    assign a0        = pair_reg[IDX_W-1:0];
    assign a1        = two_now ? pair_p1[IDX_W-1:0] : a0;
    assign scan_done = (scan_reg == cnt_reg - 1'b1);
    assign key_done  = (key_reg == cnt_reg - 1'b1);

    // stable order: an earlier index with an equal key ranks ahead
    assign p_before = (scan_b_q > key_b_q) || ((scan_b_q == key_b_q) && (scan_d_reg < key_reg));
    assign c_before = (scan_r_q < key_r_q) || ((scan_r_q == key_r_q) && (scan_d_reg < key_reg));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_LOAD:  if (!q_empty && q_data.last) state_next = BK_SCAN;
            BK_SCAN:  if (scan_done) state_next = BK_DRAIN;
            BK_DRAIN: state_next = BK_WRITE;
            BK_WRITE: state_next = key_done ? BK_FETCH : BK_SCAN;
            BK_FETCH: state_next = BK_EMIT;
            BK_EMIT:  if (!out_vld_reg || pop) state_next = last_pair ? BK_LOAD : BK_FETCH;
            default:  state_next = BK_LOAD;
        endcase
    end

    // state outputs
    always_comb
    begin
        q_rd       = 1'b0;
        scan_issue = 1'b0;
        ord_we     = 1'b0;
        fetch      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_LOAD:  q_rd = !q_empty;
            BK_SCAN:  scan_issue = 1'b1;
            BK_WRITE: ord_we = 1'b1;
            BK_FETCH: fetch = 1'b1;
            BK_EMIT:  out_load = !out_vld_reg || pop;
            default:  q_rd = 1'b0;
        endcase
        store_en = q_rd && (cnt_reg < CNT_W'(SENSOR_TOTAL));
    end

    // counters
    always_comb
    begin
        cnt_next    = cnt_reg;
        tally_next  = tally_reg;
        key_next    = key_reg;
        scan_next   = scan_reg;
        rank_p_next = rank_p_reg;
        rank_c_next = rank_c_reg;
        pair_next   = pair_reg;
        if (store_en)
        begin
            cnt_next   = cnt_reg + 1'b1;
            tally_next = tally_reg + CNT_W'(q_data.active);
        end
        if (q_rd && q_data.last)
        begin
            key_next  = '0;
            pair_next = '0;
        end
        if (ord_we)
            key_next = key_reg + 1'b1;
        if ((q_rd && q_data.last) || ord_we)
        begin
            scan_next   = '0;
            rank_p_next = '0;
            rank_c_next = '0;
        end
        else
        begin
            if (scan_issue)
                scan_next = scan_reg + 1'b1;
            if (scan_vld_reg)
            begin
                rank_p_next = rank_p_reg + IDX_W'(p_before);
                rank_c_next = rank_c_reg + IDX_W'(c_before);
            end
        end
        if (out_load)
        begin
            pair_next = pair_p2[CNT_W-1:0];
            if (last_pair)
            begin
                cnt_next   = '0;
                tally_next = '0;
            end
        end
        out_vld_next = out_load ? 1'b1 : (pop ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_LOAD;
            cnt_reg      <= '0;
            tally_reg    <= '0;
            key_reg      <= '0;
            scan_reg     <= '0;
            scan_vld_reg <= 1'b0;
            rank_p_reg   <= '0;
            rank_c_reg   <= '0;
            pair_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            tally_reg    <= tally_next;
            key_reg      <= key_next;
            scan_reg     <= scan_next;
            scan_vld_reg <= scan_issue;
            rank_p_reg   <= rank_p_next;
            rank_c_reg   <= rank_c_next;
            pair_reg     <= pair_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // value stores
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            bright_mem[cnt_reg[IDX_W-1:0]] <= q_data.bright;
            read_mem[cnt_reg[IDX_W-1:0]]   <= q_data.reading;
        end
        if (scan_issue)
        begin
            key_b_q  <= bright_mem[key_reg[IDX_W-1:0]];
            key_r_q  <= read_mem[key_reg[IDX_W-1:0]];
            scan_b_q <= bright_mem[scan_reg[IDX_W-1:0]];
            scan_r_q <= read_mem[scan_reg[IDX_W-1:0]];
        end
        scan_d_reg <= scan_reg;
    end

    // order stores
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            pos_mem[rank_p_reg]  <= key_reg[IDX_W-1:0];
            chan_mem[rank_c_reg] <= key_reg[IDX_W-1:0];
        end
        if (fetch)
        begin
            p0_q    <= pos_mem[a0];
            p1_q    <= pos_mem[a1];
            c0_q    <= chan_mem[a0];
            c1_q    <= chan_mem[a1];
            two_reg <= two_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pf_reg  <= FIELD_W'(p0_q);
            cf_reg  <= FIELD_W'(c0_q);
            ps_reg  <= two_reg ? FIELD_W'(p1_q) : '0;
            cs_reg  <= two_reg ? FIELD_W'(c1_q) : '0;
            ac_reg  <= COUNT_W'(tally_reg);
            end_reg <= last_pair;
        end
    end

    assign empty        = !out_vld_reg;
    assign pos_first    = pf_reg;
    assign chan_first   = cf_reg;
    assign pos_second   = ps_reg;
    assign chan_second  = cs_reg;
    assign active_count = ac_reg;
    assign run_end      = end_reg;

endmodule

FILE: rtl/core/rank_pair_channel_mapper.sv
// top level of the rank pair channel mapper
// depends on rpcm_pkg, rpcm_front, rpcm_fifo, rpcm_back
//
// channel   handshake        payload
// -------   ---------------  ---------------------------------------------
// items     push / full      pos_x pos_y pos_z raw_level final_item
// results   pop / empty      pos_first chan_first pos_second chan_second
//                            active_count run_end
// config    cfg_we           cfg_index cfg_data
//
// an item is registered in the dot product stage and then held in the queue
// before it lands in the stores; one item can enter every
// cycle while the queue drains
// a final item starts ranking: one compare pass over the value stores per
// stored item, then a fetch state and an emit state for each result
// reset clears all control state; stores need no clearing pass
// full stays high while ranking runs and the queue has filled; a stalled
// result holds the back part until it is popped
module rank_pair_channel_mapper #(
    parameter int SENSOR_TOTAL = 80
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item side
    input  logic                              push,
    output logic                              full,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_x,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_y,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_z,
    input  logic [rpcm_pkg::READ_W-1:0]       raw_level,
    input  logic                              final_item,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic [rpcm_pkg::FIELD_W-1:0]      pos_first,
    output logic [rpcm_pkg::FIELD_W-1:0]      chan_first,
    output logic [rpcm_pkg::FIELD_W-1:0]      pos_second,
    output logic [rpcm_pkg::FIELD_W-1:0]      chan_second,
    output logic [rpcm_pkg::COUNT_W-1:0]      active_count,
    output logic                              run_end,
    // config writes
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [rpcm_pkg::DIR_W-1:0]        cfg_data
);
    import rpcm_pkg::*;

    rpcm_sun_t sun_reg;
    rpcm_rec_t front_rec, q_rec;
    logic      front_wr, q_full, q_empty, q_rd;

    // sun direction registers, reset to straight up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sun_reg.x <= '0;
            sun_reg.y <= '0;
            sun_reg.z <= DIR_W'(16384);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUN_X: sun_reg.x <= cfg_data;
                REG_SUN_Y: sun_reg.y <= cfg_data;
                REG_SUN_Z: sun_reg.z <= cfg_data;
                default:   sun_reg   <= sun_reg;
            endcase
        end
    end

    // front: products, clamp and active flag
    rpcm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .raw_level  (raw_level),
        .final_item (final_item),
        .sun        (sun_reg),
        .rec_wr     (front_wr),
        .rec        (front_rec),
        .q_full     (q_full)
    );

    // short queue lets the front keep taking items while the back is busy
    rpcm_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (front_wr),
        .wr_data (front_rec),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rec),
        .empty   (q_empty)
    );

    // back: stores, ranking passes and result transfer
    rpcm_back #(
        .SENSOR_TOTAL (SENSOR_TOTAL)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rec),
        .q_rd         (q_rd),
        .empty        (empty),
        .pop          (pop),
        .pos_first    (pos_first),
        .chan_first   (chan_first),
        .pos_second   (pos_second),
        .chan_second  (chan_second),
        .active_count (active_count),
        .run_end      (run_end)
    );

endmodule

FILE: rtl/core/rpcm_checker.sv
// port-level checker for the rank pair channel mapper and its bind
// depends on rpcm_pkg and rank_pair_channel_mapper_assert.svh
`include "rank_pair_channel_mapper_assert.svh"

module rpcm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           empty,
    input logic                           pop,
    input logic [rpcm_pkg::FIELD_W-1:0]   pos_first,
    input logic [rpcm_pkg::FIELD_W-1:0]   chan_first,
    input logic [rpcm_pkg::FIELD_W-1:0]   pos_second,
    input logic [rpcm_pkg::FIELD_W-1:0]   chan_second,
    input logic [rpcm_pkg::COUNT_W-1:0]   active_count,
    input logic                           run_end
);
    import rpcm_pkg::*;

    `RPCM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(pos_first) && $stable(run_end), "result changed while stalled")
    `RPCM_ASSERT_NOW(a_count, !empty, active_count <= COUNT_W'(128), "active count out of range")
    `RPCM_ASSERT_NOW(a_distinct, !empty && !run_end, pos_first != pos_second && chan_first != chan_second, "pair repeats an index")
    `RPCM_ASSERT_NEXT(a_tally, !empty && pop && !run_end, empty || active_count == $past(active_count), "active count changed within a run")

endmodule

bind rank_pair_channel_mapper rpcm_checker u_rpcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .pos_first    (pos_first),
    .chan_first   (chan_first),
    .pos_second   (pos_second),
    .chan_second  (chan_second),
    .active_count (active_count),
    .run_end      (run_end)
);

FILE: bench/rank_pair_channel_mapper_checker.sv
`timescale 1ns / 100ps
// brightness ranking and channel pairing predictor plus result compare
// depends on rpcm_pkg; watches the item, result and config ports of the mapper
module rank_pair_channel_mapper_checker #(
    parameter int SENSOR_TOTAL = 80
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_x,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_y,
    input  logic signed [rpcm_pkg::DIR_W-1:0] pos_z,
    input  logic [rpcm_pkg::READ_W-1:0]       raw_level,
    input  logic                              final_item,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [rpcm_pkg::FIELD_W-1:0]      pos_first,
    input  logic [rpcm_pkg::FIELD_W-1:0]      chan_first,
    input  logic [rpcm_pkg::FIELD_W-1:0]      pos_second,
    input  logic [rpcm_pkg::FIELD_W-1:0]      chan_second,
    input  logic [rpcm_pkg::COUNT_W-1:0]      active_count,
    input  logic                              run_end,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [rpcm_pkg::DIR_W-1:0]        cfg_data,
    output int                                fail_count,
    output int                                pending
);
    import rpcm_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0] pos_a;
        logic [FIELD_W-1:0] chan_a;
        logic [FIELD_W-1:0] pos_b;
        logic [FIELD_W-1:0] chan_b;
        logic [COUNT_W-1:0] active;
        logic               last;
    } pairing_t;

    pairing_t            pairing_q[$];
    logic signed [15:0]  sun_x, sun_y, sun_z;
    logic [BRIGHT_W-1:0] bright_mem[SENSOR_TOTAL];
    logic [READ_W-1:0]   level_mem[SENSOR_TOTAL];
    int                  stored, lit_count;

    task automatic load_and_map();
        longint   dot;
        int       pos_rank[SENSOR_TOTAL];
        int       chan_rank[SENSOR_TOTAL];
        int       j, k, key;
        pairing_t pr;
        if (stored < SENSOR_TOTAL) begin
            dot = longint'(pos_x) * sun_x + longint'(pos_y) * sun_y + longint'(pos_z) * sun_z;
            if (dot < 0) dot = 0;
            if (dot > longint'(BRIGHT_MAX)) dot = longint'(BRIGHT_MAX);
            bright_mem[stored] = BRIGHT_W'(dot);
            level_mem[stored] = raw_level;
            if (dot * 100 > 64'd268435456) lit_count++;
            stored++;
        end
        if (!final_item) return;
        // stable insertion: brightest first, lowest reading first
        for (key = 0; key < stored; key++) begin
            for (j = key; j > 0 && bright_mem[pos_rank[j-1]] < bright_mem[key]; j--)
                pos_rank[j] = pos_rank[j-1];
            pos_rank[j] = key;
            for (j = key; j > 0 && level_mem[chan_rank[j-1]] > level_mem[key]; j--)
                chan_rank[j] = chan_rank[j-1];
            chan_rank[j] = key;
        end
        for (k = 0; 2 * k < stored; k++) begin
            pr.pos_a  = FIELD_W'(pos_rank[2*k]);
            pr.chan_a = FIELD_W'(chan_rank[2*k]);
            pr.pos_b  = (2*k + 1 < stored) ? FIELD_W'(pos_rank[2*k+1]) : '0;
            pr.chan_b = (2*k + 1 < stored) ? FIELD_W'(chan_rank[2*k+1]) : '0;
            pr.active = COUNT_W'(lit_count);
            pr.last   = (2*k + 2 >= stored);
            pairing_q.push_back(pr);
        end
        stored = 0;
        lit_count = 0;
    endtask

    task automatic compare_pairing();
        pairing_t got, want;
        got = '{pos_first, chan_first, pos_second, chan_second, active_count, run_end};
        if (pairing_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t unexpected result %h", $realtime, got);
            return;
        end
        want = pairing_q.pop_front();
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t result mismatch: expected pos %0d/%0d chan %0d/%0d act %0d end %0d, got pos %0d/%0d chan %0d/%0d act %0d end %0d",
                         $realtime, want.pos_a, want.pos_b, want.chan_a, want.chan_b,
                         want.active, want.last, got.pos_a, got.pos_b, got.chan_a,
                         got.chan_b, got.active, got.last);
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sun_x = 0;
            sun_y = 0;
            sun_z = 16384;
            stored = 0;
            lit_count = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SUN_X: sun_x = cfg_data;
                    REG_SUN_Y: sun_y = cfg_data;
                    REG_SUN_Z: sun_z = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full) load_and_map();
            if (pop && !empty) compare_pairing();
        end
        pending = pairing_q.size();
    end
endmodule

FILE: bench/rank_pair_channel_mapper_tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the rank pair channel mapper
// depends on rpcm_pkg, rank_pair_channel_mapper and rank_pair_channel_mapper_checker
module rank_pair_channel_mapper_tb;
    import rpcm_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic signed [15:0]  pos_x = '0, pos_y = '0, pos_z = '0;
    logic [READ_W-1:0]   raw_level = '0;
    logic                final_item = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [FIELD_W-1:0]  pos_first, chan_first, pos_second, chan_second;
    logic [COUNT_W-1:0]  active_count;
    logic                run_end;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = REG_SUN_X;
    logic [DIR_W-1:0]    cfg_data = '0;
    int                  fail_count, pending;
    int                  items_sent = 0;
    int                  pop_hold = 0;
    bit                  no_idle = 1'b0;

    always #2 clk = ~clk;

    rank_pair_channel_mapper #(.SENSOR_TOTAL(80)) i_dut (.*);

    rank_pair_channel_mapper_checker #(.SENSOR_TOTAL(80)) i_chk (.*);

    // result side: mostly short stalls, now and then a long one
    always @(negedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (pop_hold > 0) begin
            pop = 1'b0;
            pop_hold--;
        end
        else if (no_idle)
            pop = 1'b1;
        else begin
            if (r < 3) pop_hold = $urandom_range(20, 60);
            pop = (r >= 30);
        end
    end

    // sender gap, called at a falling edge
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r >= 40) return;
        push = 1'b0;
        repeat (r < 4 ? $urandom_range(20, 60) : $urandom_range(1, 3)) @(negedge clk);
    endtask

    // one item transfer; starts and ends on a falling edge
    task automatic send_item(input logic signed [15:0] x, y, z,
                             input logic [READ_W-1:0] lvl, input logic fin);
        idle_gap();
        push = 1'b1;
        pos_x = x;
        pos_y = y;
        pos_z = z;
        raw_level = lvl;
        final_item = fin;
        while (full) @(negedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // hold off until every expected pairing has come and the block is quiet
    task automatic drain();
        push = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_sun(input logic [15:0] sx, sy, sz);
        drain();
        cfg_we = 1'b1;
        cfg_index = REG_SUN_X;
        cfg_data = sx;
        @(negedge clk);
        cfg_index = REG_SUN_Y;
        cfg_data = sy;
        @(negedge clk);
        cfg_index = REG_SUN_Z;
        cfg_data = sz;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] any_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 16'($urandom_range(0, 32768) - 16384);
        if (r == 7) return 16'($urandom);
        return (r == 8) ? 16'sd16384 : -16'sd16384;
    endfunction

    function automatic logic [READ_W-1:0] any_level();
        // narrow range now and then so readings tie
        if ($urandom_range(0, 3) == 0) return READ_W'($urandom_range(0, 3));
        return READ_W'($urandom_range(0, 4095));
    endfunction

    task automatic random_set(input int n);
        no_idle = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n; i++)
            send_item(any_comp(), any_comp(), any_comp(), any_level(), i == n - 1);
    endtask

    initial begin
        #2_000_000;
        $display("rank_pair_channel_mapper verification failed");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset sun points along z: straight up, straight down, just around the
        // activity threshold, tied readings, even set size
        send_item(16'sd0, 16'sd0, 16'sd16384, 12'd0, 1'b0);
        send_item(16'sd0, 16'sd0, -16'sd16384, 12'd4095, 1'b0);
        send_item(16'sd16384, 16'sd16384, 16'sd16384, 12'd100, 1'b0);
        send_item(16'sd0, 16'sd0, 16'sd163, 12'd100, 1'b0);
        send_item(16'sd0, 16'sd0, 16'sd164, 12'd100, 1'b0);
        send_item(16'sd0, 16'sd0, 16'sd164, 12'd0, 1'b1);
        // lone final item, odd count of one
        send_item(16'sd100, -16'sd100, 16'sd8192, 12'd2047, 1'b1);

        // a sun of 16384 on all three axes saturates the brightness
        set_sun(16'sd16384, 16'sd16384, 16'sd16384);
        send_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 12'd7, 1'b0);
        send_item(-16'sh8000, -16'sh8000, -16'sh8000, 12'd7, 1'b0);
        send_item(16'sh7fff, 16'sd0, -16'sh8000, 12'd3, 1'b1);

        // register values at the full data width and the negative extreme
        set_sun(16'h8000, 16'h7fff, -16'sd16384);
        send_item(-16'sd16384, 16'sd16384, -16'sd16384, 12'hAAA, 1'b0);
        send_item(16'sd16384, -16'sd16384, 16'sd16384, 12'h555, 1'b0);
        send_item(16'sd0, 16'sd0, 16'sd0, 12'hFFF, 1'b1);

        // one exact full set, then an overfull set whose extra items are dropped
        set_sun(-16'sd16384, 16'sd0, 16'sd16384);
        random_set(80);
        set_sun(16'sd9000, -16'sd5000, 16'sd12000);
        random_set(83);

        while (items_sent < 270) begin
            if ($urandom_range(0, 3) == 0)
                set_sun(any_comp(), any_comp(), any_comp());
            else if ($urandom_range(0, 5) == 0)
                drain();
            random_set($urandom_range(1, 12));
        end

        drain();
        pop_hold = 0;
        if (fail_count == 0)
            $display("rank_pair_channel_mapper verification clean");
        else
            $display("rank_pair_channel_mapper verification failed");
        $finish;
    end
endmodule

FILE: rank_pair_channel_mapper.f
+incdir+rtl/core
rtl/core/rpcm_pkg.sv
rtl/core/rpcm_fifo.sv
rtl/core/rpcm_front.sv
rtl/core/rpcm_back.sv
rtl/core/rank_pair_channel_mapper.sv
rtl/core/rpcm_checker.sv
bench/rank_pair_channel_mapper_checker.sv
bench/rank_pair_channel_mapper_tb.sv
